// File: hdl/lzwve_pkg.sv
// Shared types, constants and code-width helpers for the LZW encoder.
package lzwve_pkg;

	localparam int MAX_CODE_BITS = 12;
	localparam int CODE_W        = MAX_CODE_BITS;
	localparam int TRIE_AW       = CODE_W + 8;
	localparam int TRIE_DEPTH    = 1 << TRIE_AW;
	localparam int EPOCH_W       = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = 2;
	localparam int MAX_RESULTS   = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_GIF_MODE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE_SIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CODE_BITS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_WITH_CLEAR = 2'd3;

	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code;
		logic [4:0]  code_width;
		logic        run_end;
	} out_item_t;

	typedef struct packed {
		logic       gif_mode;
		logic [3:0] min_code_size;
		logic [4:0] max_code_bits;
		logic       start_with_clear;
	} cfg_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		code_t              code;
	} trie_entry_t;

	typedef struct packed {
		logic               rd_en;
		logic [TRIE_AW-1:0] rd_addr;
		logic               wr_en;
		logic [TRIE_AW-1:0] wr_addr;
		trie_entry_t        wr_data;
	} trie_req_t;

	typedef struct packed {
		logic [1:0]                      n;
		out_item_t [MAX_RESULTS-1:0]     res;
	} push_t;

	// Number of bits needed to hold v, at least one.
	function automatic logic [4:0] bits_of(input code_t v);
		logic [4:0] n;
		n = 5'd1;
		for (int i = 0; i < CODE_W; i++) begin
			if (v[i]) begin
				n = 5'(i + 1);
			end
		end
		return n;
	endfunction

	// Width growth before a code goes out; .Z drops the step at 256.
	function automatic logic [4:0] widen(input code_t nfc, input logic [4:0] w,
			input logic [4:0] emax, input code_t limit, input logic gif);
		code_t t;
		logic  grow;
		t = nfc - code_t'(1);
		grow = (nfc < limit) && ((t & (t - code_t'(1))) == '0) && (w < emax)
			&& !(!gif && (t == code_t'(256)));
		return grow ? w + 5'd1 : w;
	endfunction

endpackage

// File: hdl/lzw_variable_width_encoder.sv
// Top level of the LZW encoder with GIF and .Z code-width rules.
//
// channel   direction  handshake                payload
// item      in         item_valid / item_stall  in_item_t  (data_byte, last_byte)
// result    out        result_valid / result_stall  out_item_t (code, code_width, run_end)
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// An item is accepted, then its write-back slot follows: the trie read is issued on the
// accept edge and the write-back of a new entry lands in the next cycle on the same memory port.
// Each item yields 0 to 3 results; the queue drains one beat per cycle while result_stall is low.
// After reset, and after every 65535 streams, a sweep over all 2^20 trie entries clears the
// trie tags; item_stall stays high during it, cfg writes are taken as ever.
// item_stall is also high while an item is in flight or the queue holds 2+ beats.
module lzw_variable_width_encoder import lzwve_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	trie_req_t        trie_req;
	trie_entry_t      trie_rd;
	logic             start_clear;
	logic             clear_busy;
	logic             core_busy;
	push_t            push;
	logic [FIFO_AW:0] fifo_count;
	logic             fire;

	assign cfg_ready  = 1'b1;
	assign item_stall = clear_busy || core_busy || (fifo_count > (FIFO_AW + 1)'(1));
	assign fire       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{gif_mode: 1'b1, min_code_size: 4'd8, max_code_bits: 5'd12,
				start_with_clear: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GIF_MODE:         cfg_q.gif_mode         <= cfg_data[0];
				CFG_MIN_CODE_SIZE:    cfg_q.min_code_size    <= cfg_data[3:0];
				CFG_MAX_CODE_BITS:    cfg_q.max_code_bits    <= cfg_data;
				CFG_START_WITH_CLEAR: cfg_q.start_with_clear <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	lzwve_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.fire        (fire),
		.item        (item),
		.rd_data     (trie_rd),
		.trie_req    (trie_req),
		.start_clear (start_clear),
		.busy        (core_busy),
		.push        (push)
	);

	lzwve_trie u_trie (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (trie_req),
		.start_clear (start_clear),
		.rd_data     (trie_rd),
		.busy        (clear_busy)
	);

	lzwve_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.count        (fifo_count)
	);

	// the write-back slot must follow every accept
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !fire)
		else $error("item accepted in the write-back cycle");

	a_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(trie_req.rd_en && trie_req.wr_en))
		else $error("trie read and write in the same cycle");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> ((FIFO_AW + 2)'(fifo_count) + (FIFO_AW + 2)'(push.n)
			<= (FIFO_AW + 2)'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !trie_req.wr_en && !trie_req.rd_en)
		else $error("trie access during tag sweep");

endmodule

// File: hdl/lzwve_trie.sv
// Trie memory with epoch-tagged entries and the sweep that clears the tags.
module lzwve_trie import lzwve_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  trie_req_t   req,
	input  logic        start_clear,
	output trie_entry_t rd_data,
	output logic        busy
);

	trie_entry_t        mem [TRIE_DEPTH];
	logic [TRIE_AW-1:0] sweep_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end else if (busy_q) begin
			sweep_q <= sweep_q + TRIE_AW'(1);
			if (sweep_q == {TRIE_AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end else if (start_clear) begin
			busy_q  <= 1'b1;
			sweep_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[sweep_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

// File: hdl/lzwve_core.sv
// Encoder state: trie lookup issue, hit/miss decision, width rules, result list.
module lzwve_core import lzwve_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        fire,
	input  in_item_t    item,
	input  trie_entry_t rd_data,
	output trie_req_t   trie_req,
	output logic        start_clear,
	output logic        busy,
	output push_t       push
);

	logic               valid_s1;
	logic [7:0]         b_s1;
	logic               last_s1;
	code_t              prefix_q;
	logic               have_q;
	code_t              nfc_q;
	logic [4:0]         width_q;
	logic [EPOCH_W-1:0] epoch_q;

	logic [3:0] m;
	logic [8:0] clr;
	code_t      clr_code;
	logic [4:0] emax;
	code_t      limit;
	logic [7:0] b_in;
	code_t      nfc_a;
	code_t      prefix_a;
	logic [4:0] w_a;
	logic [4:0] w_b;
	logic [1:0] cnt;
	logic       wr;

	always_comb begin
		if (cfg.min_code_size < 4'd2) begin
			m = 4'd2;
		end else if (cfg.min_code_size > 4'd8) begin
			m = 4'd8;
		end else begin
			m = cfg.min_code_size;
		end
		if (cfg.max_code_bits < 5'd9) begin
			emax = 5'd9;
		end else if (cfg.max_code_bits > 5'(MAX_CODE_BITS)) begin
			emax = 5'(MAX_CODE_BITS);
		end else begin
			emax = cfg.max_code_bits;
		end
		clr      = 9'd1 << m;
		clr_code = CODE_W'(clr);
		limit    = {CODE_W{1'b1}} >> (5'(CODE_W) - emax);
		b_in     = item.data_byte & 8'(clr - 9'd1);
	end

	// Decide the beat in s1 from the registered trie read.
	always_comb begin
		push     = '0;
		cnt      = 2'd0;
		wr       = 1'b0;
		nfc_a    = nfc_q;
		w_a      = width_q;
		w_b      = width_q;
		prefix_a = prefix_q;
		if (!have_q) begin
			nfc_a = clr_code + (cfg.gif_mode ? code_t'(2) : code_t'(1));
			w_a   = bits_of(nfc_a);
			if (cfg.gif_mode && cfg.start_with_clear) begin
				push.res[cnt] = '{code: 16'(clr_code), code_width: 5'(m) + 5'd1,
					run_end: 1'b0};
				cnt = cnt + 2'd1;
			end
			prefix_a = CODE_W'(b_s1);
		end else if (rd_data.tag == epoch_q) begin
			prefix_a = rd_data.code;
		end else begin
			w_a = widen(nfc_q, width_q, emax, limit, cfg.gif_mode);
			push.res[cnt] = '{code: 16'(prefix_q), code_width: w_a, run_end: 1'b0};
			cnt = cnt + 2'd1;
			if (nfc_q < limit) begin
				nfc_a = nfc_q + code_t'(1);
				// drop the write on the last byte: the stream end advances the epoch, so it goes stale anyway
				wr    = !last_s1;
			end
			prefix_a = CODE_W'(b_s1);
		end
		if (last_s1) begin
			w_b = widen(nfc_a, w_a, emax, limit, cfg.gif_mode);
			push.res[cnt] = '{code: 16'(prefix_a), code_width: w_b, run_end: 1'b0};
			cnt = cnt + 2'd1;
			if (cfg.gif_mode) begin
				push.res[cnt] = '{code: 16'(clr_code + code_t'(1)),
					code_width: bits_of(nfc_a - code_t'(1)), run_end: 1'b0};
				cnt = cnt + 2'd1;
			end
		end
		if (cnt != 2'd0) begin
			push.res[cnt - 2'd1].run_end = 1'b1;
		end
		push.n = valid_s1 ? cnt : 2'd0;
	end

	always_comb begin
		trie_req.rd_en   = fire && have_q;
		trie_req.rd_addr = {prefix_q, b_in};
		trie_req.wr_en   = valid_s1 && wr;
		trie_req.wr_addr = {prefix_q, b_s1};
		trie_req.wr_data = '{tag: epoch_q, code: nfc_q};
	end

	assign start_clear = valid_s1 && last_s1 && (epoch_q == {EPOCH_W{1'b1}});
	assign busy        = valid_s1;

	always_ff @(posedge clk) begin
		if (fire) begin
			b_s1    <= b_in;
			last_s1 <= item.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prefix_q <= '0;
			have_q   <= 1'b0;
			nfc_q    <= '0;
			width_q  <= '0;
			epoch_q  <= EPOCH_W'(1);
		end else begin
			valid_s1 <= fire;
			if (valid_s1) begin
				nfc_q   <= nfc_a;
				width_q <= w_a;
				if (last_s1) begin
					prefix_q <= '0;
					have_q   <= 1'b0;
					// advance the epoch; on wrap the sweep resets all tags
					epoch_q  <= (epoch_q == {EPOCH_W{1'b1}}) ? EPOCH_W'(1)
						: epoch_q + EPOCH_W'(1);
				end else begin
					prefix_q <= prefix_a;
					have_q   <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/lzwve_fifo.sv
// Result queue: takes up to three results a cycle, hands out one beat a cycle unless result_stall is high.
module lzwve_fifo import lzwve_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	input  logic             result_stall,
	output logic             result_valid,
	output out_item_t        result,
	output logic [FIFO_AW:0] count
);

	out_item_t          buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;

	assign result_valid = (count_q != '0);
	assign result       = buf_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	assign count        = count_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (2'(k) < push.n) begin
				buf_q[wr_ptr_q + FIFO_AW'(k)] <= push.res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW + 1)'(push.n) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule
